### design/ipcidr_pkg.sv
// ipcidr_pkg: payload and control types shared by the CIDR cover block.
// No dependencies; imported by ipcidr_dp, ipcidr_ctrl and the core.
`timescale 1ns / 1ps

package ipcidr_pkg;

  localparam int unsigned FIELD_ADDR_W = 32;
  localparam int unsigned PREFIX_W     = 6;

  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] range_low;
    logic [FIELD_ADDR_W-1:0] range_high;
  } range_item_t;

  typedef struct packed {
    logic [FIELD_ADDR_W-1:0] block_base;
    logic [PREFIX_W-1:0]     prefix_len;
    logic                    last_block;
    logic                    range_error;
    logic                    truncated;
  } block_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture a new range
    logic emit;   // write current block to output register and step
  } ipcidr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // block at the current address ends this range
  } ipcidr_sts_t;

endpackage

### design/ipcidr_dp.sv
// ipcidr_dp: address walk datapath, block size step and output register.
// Depends on ipcidr_pkg.
`timescale 1ns / 1ps

module ipcidr_dp #(
  parameter int unsigned ADDR_BITS  = 32,
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic                      clk,
  input  ipcidr_pkg::range_item_t   range_data,
  input  ipcidr_pkg::ipcidr_cmd_t   cmd,
  output ipcidr_pkg::ipcidr_sts_t   sts,
  output ipcidr_pkg::block_item_t   block_data
);
  import ipcidr_pkg::*;

  localparam int unsigned AW1 = ADDR_BITS + 1;
  localparam int unsigned CW  = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned KW  = $clog2(ADDR_BITS + 1);

  logic [ADDR_BITS-1:0] lo_in, hi_in;
  logic [ADDR_BITS-1:0] cur, cur_next;
  logic [AW1-1:0]       rem, rem_next;       // addresses left, hi - cur + 1
  logic                 err;
  logic [CW-1:0]        count;

  logic [AW1-1:0]       smear;
  logic [ADDR_BITS-1:0] fit_mask, align_mask, blk_mask;
  logic [AW1-1:0]       blk_mask_ext;
  logic [KW-1:0]        k_enc;
  logic                 done, trunc;
  block_item_t          res;

  assign lo_in = range_data.range_low[ADDR_BITS-1:0];
  assign hi_in = range_data.range_high[ADDR_BITS-1:0];

  // largest 2^k <= rem: smear rem right, mask is smear >> 1
  always_comb begin
    smear = rem;
    for (int i = 0; (1 << i) < AW1; i++) begin
      smear = smear | (smear >> (1 << i));
    end
  end
  assign fit_mask = smear[AW1-1:1];

  // alignment: trailing zeros of cur, whole space when cur is zero
  assign align_mask = (cur == '0) ? '1 : ((cur - 1'b1) & ~cur);
  assign blk_mask   = fit_mask & align_mask;

  // thermometer to count: find the top edge of the mask
  assign blk_mask_ext = {1'b0, blk_mask};
  always_comb begin
    k_enc = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (blk_mask_ext[i] && !blk_mask_ext[i+1]) begin
        k_enc = k_enc | KW'(i + 1);
      end
    end
  end

  assign rem_next = rem - blk_mask_ext - 1'b1;
  assign cur_next = cur + blk_mask + 1'b1;
  assign done     = (rem_next == '0);
  assign trunc    = !done && (count == CW'(MAX_BLOCKS - 1));

  assign sts.last = err || done || trunc;

  always_comb begin
    if (err) begin
      res.block_base  = '0;
      res.prefix_len  = '0;
      res.last_block  = 1'b1;
      res.range_error = 1'b1;
      res.truncated   = 1'b0;
    end else begin
      res.block_base  = FIELD_ADDR_W'(cur);
      res.prefix_len  = PREFIX_W'(ADDR_BITS) - PREFIX_W'(k_enc);
      res.last_block  = done || trunc;
      res.range_error = 1'b0;
      res.truncated   = trunc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= lo_in;
      rem   <= {1'b0, hi_in} - {1'b0, lo_in} + 1'b1;
      err   <= (lo_in > hi_in);
      count <= '0;
    end else if (cmd.emit) begin
      cur   <= cur_next;
      rem   <= rem_next;
      count <= count + 1'b1;
    end
    if (cmd.emit) begin
      block_data <= res;
    end
  end

endmodule

### design/ipcidr_ctrl.sv
// ipcidr_ctrl: sequencer for range intake and block output handshakes.
// Depends on ipcidr_pkg.
`timescale 1ns / 1ps

module ipcidr_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    range_valid,
  output logic                    range_ready,
  output logic                    block_valid,
  input  logic                    block_ready,
  output ipcidr_pkg::ipcidr_cmd_t cmd,
  input  ipcidr_pkg::ipcidr_sts_t sts
);
  import ipcidr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state, state_next;
  logic out_full, out_full_next;

  assign range_ready = (state == ST_IDLE);
  assign block_valid = out_full;

  assign cmd.load = range_valid && range_ready;
  assign cmd.emit = (state == ST_RUN) && (!out_full || block_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (cmd.emit && sts.last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_full_next = 1'b1;
    end else if (block_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

### design/ip_range_to_cidr_blocks_core.sv
// ip_range_to_cidr_blocks_core: covers an inclusive address range with CIDR blocks.
// Depends on ipcidr_pkg, ipcidr_ctrl and ipcidr_dp.
`timescale 1ns / 1ps

// Takes one inclusive range (range_low..range_high) per transfer on the range
// channel and sends, in ascending order, the minimal set of aligned CIDR blocks
// that covers it, one block per transfer on the block channel. Each block is the
// largest one aligned at the current address that stays inside the range;
// last_block marks the final block of a range. A reversed range (low above
// high) gives a single result with range_error set. After MAX_BLOCKS blocks the
// walk stops and the final block carries truncated and last_block. Addresses
// are cut to their low ADDR_BITS bits first. A range is captured first, then
// its blocks are stepped out one by one (at most MAX_BLOCKS); a step waits
// while the output register is full and block_ready is low. Each step does the
// remaining-size smear, the alignment mask and one subtract for the remaining
// count. The next range is taken once the final block of the current one is
// in the output register, even while that block still waits for block_ready.
module ip_range_to_cidr_blocks_core #(
  parameter int unsigned MAX_BLOCKS = 32,   // 1..62
  parameter int unsigned ADDR_BITS  = 32    // 8..32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    range_valid,
  output logic                    range_ready,
  input  ipcidr_pkg::range_item_t range_data,
  output logic                    block_valid,
  input  logic                    block_ready,
  output ipcidr_pkg::block_item_t block_data
);
  import ipcidr_pkg::*;

  ipcidr_cmd_t cmd;
  ipcidr_sts_t sts;

  // Controller: owns range_ready, block_valid and the run/idle state.
  ipcidr_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .range_valid (range_valid),
    .range_ready (range_ready),
    .block_valid (block_valid),
    .block_ready (block_ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Datapath: current address, remaining size, block count, output payload.
  ipcidr_dp #(
    .ADDR_BITS  (ADDR_BITS),
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk        (clk),
    .range_data (range_data),
    .cmd        (cmd),
    .sts        (sts),
    .block_data (block_data)
  );

`ifndef SYNTHESIS
  // one range in flight: intake is closed right after a range is captured
  a_one_range: assert property (@(posedge clk) disable iff (rst)
    (range_valid && range_ready) |=> !range_ready)
    else $error("range accepted twice in a row");

  // error result is final, untruncated and carries no block
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    (block_valid && block_data.range_error) |->
      (block_data.last_block && !block_data.truncated &&
       block_data.prefix_len == '0 && block_data.block_base == '0))
    else $error("malformed range error result");

  // truncation only on the final result
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    (block_valid && block_data.truncated) |-> block_data.last_block)
    else $error("truncated result not marked last");

  // prefix never exceeds the address width
  a_prefix_rng: assert property (@(posedge clk) disable iff (rst)
    block_valid |-> (block_data.prefix_len <= PREFIX_W'(ADDR_BITS)))
    else $error("prefix length out of range");
`endif

endmodule

### tb/ip_range_to_cidr_blocks_core_tb.sv
// ip_range_to_cidr_blocks_core_tb: self-checking bench for the CIDR cover core.
// Depends on ipcidr_pkg and ip_range_to_cidr_blocks_core; predicts every block
// in a local model and checks each block transfer against it in order.
`timescale 1ns / 1ps

module ip_range_to_cidr_blocks_core_tb;
  import ipcidr_pkg::*;

  localparam int unsigned MAX_BLOCKS   = 32;
  localparam int unsigned ADDR_BITS    = 32;
  // Drain wait: the full block walk of one range, with margin for the output register.
  localparam int unsigned DRAIN_CYCLES = MAX_BLOCKS + 8;
  // Watchdog limit, with wide margin over the slowest legal run of ~250 ranges x 32 blocks.
  localparam int unsigned CYCLE_LIMIT  = 700000;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        range_valid = 1'b0;
  logic        range_ready;
  range_item_t range_data  = '0;
  logic        block_valid;
  logic        block_ready = 1'b0;
  block_item_t block_data;

  // Blocks predicted for accepted ranges, oldest first.
  block_item_t expected_blocks[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          idle_en    = 1'b1;   // random bubbles on both channels
  int unsigned stall_left = 0;

  ip_range_to_cidr_blocks_core #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .range_valid(range_valid),
    .range_ready(range_ready),
    .range_data (range_data),
    .block_valid(block_valid),
    .block_ready(block_ready),
    .block_data (block_data)
  );

  always #5 clk = ~clk;

  // Cover model: walk from the low address, each step taking the largest
  // block aligned at the current address that stays inside the range.
  // 64-bit math keeps cur + size - 1 from wrapping at the top of the space.
  function automatic void cover_range(range_item_t r);
    logic [63:0] amask, lo, hi, cur, size;
    int          k;
    int          count;
    bit          done_b, trunc_b;
    block_item_t b;
    amask = (64'd1 << ADDR_BITS) - 64'd1;
    lo    = {32'd0, r.range_low} & amask;
    hi    = {32'd0, r.range_high} & amask;
    if (lo > hi) begin
      // Reversed range: one error result, no block.
      b             = '0;
      b.last_block  = 1'b1;
      b.range_error = 1'b1;
      expected_blocks.push_back(b);
      return;
    end
    cur   = lo;
    count = 0;
    while (cur <= hi && count < MAX_BLOCKS) begin
      k = ADDR_BITS;
      while (k > 0) begin
        size = 64'd1 << k;
        if (((cur & (size - 64'd1)) == 64'd0) && (cur + size - 64'd1 <= hi)) break;
        k--;
      end
      size    = 64'd1 << k;
      done_b  = (cur + size - 64'd1) >= hi;
      trunc_b = !done_b && (count + 1 >= MAX_BLOCKS);
      b.block_base  = cur[31:0];
      b.prefix_len  = PREFIX_W'(ADDR_BITS - k);
      b.last_block  = done_b || trunc_b;
      b.range_error = 1'b0;
      b.truncated   = trunc_b;
      expected_blocks.push_back(b);
      count++;
      if (done_b || trunc_b) break;
      cur += size;
    end
  endfunction

  // Random range, mostly well-formed with random span, plus aligned blocks,
  // singles, ranges at the ends of the space, and reversed pairs.
  function automatic range_item_t rand_range();
    range_item_t r;
    logic [63:0] lo, hi, size;
    int          k;
    r.range_low  = $urandom;
    r.range_high = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        k  = $urandom_range(0, 32);
        lo = {32'd0, r.range_low};
        hi = lo + ({32'd0, $urandom} >> (32 - k));
        if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
        r.range_high = hi[31:0];
      end
      5: ;  // fully random pair: often reversed or cut off by the limit
      6: begin
        k    = $urandom_range(0, 32);
        size = 64'd1 << k;
        lo   = {32'd0, $urandom} & ~(size - 64'd1);
        hi   = lo + size - 64'd1;
        r.range_low  = lo[31:0];
        r.range_high = hi[31:0];
      end
      7: r.range_high = r.range_low;
      8: begin
        if ($urandom_range(0, 1)) begin
          r.range_low  = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
          r.range_high = 32'hFFFF_FFFF;
        end else begin
          r.range_low  = 32'd0;
          r.range_high = 32'($urandom_range(0, 300));
        end
      end
      default: r.range_high = r.range_low - 32'($urandom_range(1, 1000));
    endcase
    return r;
  endfunction

  // One range transfer. Valid is left high after the transfer so the next
  // call can follow back to back; a gap or a drain lowers it.
  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi);
    range_item_t r;
    r.range_low  = lo;
    r.range_high = hi;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      range_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    range_valid <= 1'b1;
    range_data  <= r;
    do @(posedge clk); while (!range_ready);
    cover_range(r);
  endtask

  // Stop sending and let every predicted block come out, then give the core
  // its full walk time so nothing stray is still in flight.
  task automatic wait_all_blocks();
    range_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_edge_ranges();
    send_range(32'h0000_0000, 32'hFFFF_FFFF);   // whole space, prefix 0
    send_range(32'h0000_0005, 32'h0000_0005);   // single address
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_000A, 32'h0000_0005);   // reversed
    send_range(32'hFFFF_FFFF, 32'h0000_0000);   // reversed, extremes
    send_range(32'h0000_0001, 32'h0000_0002);   // odd start, final address kept
    send_range(32'h0000_0003, 32'h0000_0004);
    send_range(32'h0000_0000, 32'h0000_0001);
    send_range(32'h8000_0000, 32'hFFFF_FFFF);
    send_range(32'hC0A8_0001, 32'hC0A8_00FE);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'hAAAA_AAAA, 32'h5555_5555);   // reversed, alternating bits
    send_range(32'h5555_5555, 32'hAAAA_AAAA);
  endtask

  task automatic test_block_limit();
    send_range(32'h0000_0001, 32'h7FFF_FFFF);   // 31 blocks
    send_range(32'h0000_0001, 32'h8000_0000);   // exactly the limit, not cut
    send_range(32'h0000_0001, 32'h8000_0001);   // also exactly the limit, not cut
    send_range(32'h0000_0001, 32'hFFFF_FFFE);   // far over
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
  endtask

  task automatic test_random_ranges(input int unsigned n);
    range_item_t r;
    repeat (n) begin
      r = rand_range();
      send_range(r.range_low, r.range_high);
    end
  endtask

  // Sender holds off until the block channel has fully drained.
  task automatic test_drain_pause();
    range_item_t r;
    repeat (3) begin
      r = rand_range();
      send_range(r.range_low, r.range_high);
    end
    wait_all_blocks();
    send_range(32'h0000_0001, 32'hFFFF_FFFE);
  endtask

  task automatic test_back_to_back(input int unsigned n);
    idle_en = 1'b0;
    test_random_ranges(n);
  endtask

  // Block receiver: ready drops in random bursts while bubbles are enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      block_ready <= 1'b0;
    end else if (idle_en && !rst && $urandom_range(0, 3) == 0) begin
      stall_left  <= $urandom_range(0, 2);
      block_ready <= 1'b0;
    end else begin
      block_ready <= 1'b1;
    end
  end

  // Block checker and run watchdog.
  always @(posedge clk) begin
    block_item_t exp_b;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL ip_range_to_cidr_blocks_core");
      $finish;
    end
    if (!rst && block_valid && block_ready) begin
      if (expected_blocks.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected block transfer, expected none, actual %h",
                 $time, block_data);
      end else begin
        exp_b = expected_blocks.pop_front();
        if (block_data.block_base !== exp_b.block_base) begin
          mismatches = mismatches + 1;
          $display("%0t: block_base expected %h actual %h",
                   $time, exp_b.block_base, block_data.block_base);
        end
        if (block_data.prefix_len !== exp_b.prefix_len) begin
          mismatches = mismatches + 1;
          $display("%0t: prefix_len expected %0d actual %0d",
                   $time, exp_b.prefix_len, block_data.prefix_len);
        end
        if (block_data.last_block !== exp_b.last_block) begin
          mismatches = mismatches + 1;
          $display("%0t: last_block expected %b actual %b",
                   $time, exp_b.last_block, block_data.last_block);
        end
        if (block_data.range_error !== exp_b.range_error) begin
          mismatches = mismatches + 1;
          $display("%0t: range_error expected %b actual %b",
                   $time, exp_b.range_error, block_data.range_error);
        end
        if (block_data.truncated !== exp_b.truncated) begin
          mismatches = mismatches + 1;
          $display("%0t: truncated expected %b actual %b",
                   $time, exp_b.truncated, block_data.truncated);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_edge_ranges();
    test_block_limit();
    test_random_ranges(150);
    test_drain_pause();
    test_back_to_back(30);
    wait_all_blocks();
    // Leftover expectations count as failures too.
    if (mismatches == 0 && expected_blocks.size() == 0) begin
      $display("PASS ip_range_to_cidr_blocks_core");
    end else begin
      $display("FAIL ip_range_to_cidr_blocks_core");
    end
    $finish;
  end

endmodule
